// ===== rtl/rast_pkg.sv =====
// Shared types and constants for the resolver angle and speed tracker.
// Depends on nothing; imported by rtl/resolver_angle_speed_tracker_unit.sv.

package rast_pkg;

   // Quadrature counts per mechanical turn, as a power of two.
   localparam int unsigned CountBits = 12;
   localparam int unsigned AngleBits = 16;
   localparam int unsigned PoleBits  = 6;
   // Position within one turn in 1/65536 count.
   localparam int unsigned PosBits   = CountBits + AngleBits;

   // Register reset values.
   localparam logic [PoleBits-1:0] PolePairsReset = 6'd4;
   localparam logic [31:0]         SpeedGainReset = 32'd257359217;

   // Configuration register indexes.
   localparam logic CSR_POLE_PAIRS = 1'b0;
   localparam logic CSR_SPEED_GAIN = 1'b1;

   // Request opcodes.
   localparam logic [1:0] OP_STARTUP = 2'd0;
   localparam logic [1:0] OP_INDEX   = 2'd1;
   localparam logic [1:0] OP_UPDATE  = 2'd2;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_POS,
      ST_ELEC,
      ST_TAKE,
      ST_SPD_LO,
      ST_SPD_HI,
      ST_SPD_ACC,
      ST_FIN
   } seq_state_type;

endpackage

// ===== rtl/resolver_angle_speed_tracker_unit.sv =====
// Resolver angle and speed tracker: top level with sequencer, divider and shared multiplier.
// Depends on rtl/rast_pkg.sv.
//
// Path to the response register: an ignored word goes straight to commit, an aligned update
// runs the angle and speed states, a start-up the 16-step serial divide, an unaligned update
// the divide and speed states, the first index the divide, position and angle states.
// Throughput: one request word at a time; a new word is taken as soon as the previous one has
// been committed to the response register, even while that response still waits downstream.
// Reset (synchronous, active high) restores the register defaults and clears all held state.

module resolver_angle_speed_tracker_unit
   import rast_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [31:0] counter_value, [47:32] converter_angle
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] elec_angle, [31:16] mech_angle, [63:32] speed, [64] aligned,
   // [65] load_counter, [77:66] load_value, [79:78] zero
   output logic [79:0] rsp_tdata,
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   // Configuration registers.
   logic [PoleBits-1:0] pole_pairs_ff;
   logic [31:0]         speed_gain_ff;
   logic [PoleBits-1:0] pp_eff;

   // Held state across requests, and the registers that the response reports.
   logic                 is_aligned_ff;
   logic [AngleBits-1:0] startup_elec_ff;
   logic [CountBits-1:0] startup_count_ff;
   logic [31:0]          previous_count_ff;
   logic [AngleBits-1:0] elec_held_ff;
   logic [AngleBits-1:0] mech_held_ff;
   logic [31:0]          speed_held_ff;
   logic                 load_ff;
   logic [CountBits-1:0] load_value_ff;
   logic                 rsp_valid_ff;

   // Sequencer and work registers.
   seq_state_type        state_ff, state_in;
   logic [3:0]           step_ff;
   logic [1:0]           op_ff;
   logic                 work_aligned_ff;
   logic [31:0]          cnt_ff;
   logic [AngleBits-1:0] conv_ff;
   logic [31:0]          mag_ff;
   logic                 neg_ff;
   logic [AngleBits-1:0] div_q_ff;
   logic [PoleBits-1:0]  div_r_ff;
   logic [PosBits-1:0]   pos_ff;
   logic [AngleBits-1:0] work_elec_ff;
   logic [47:0]          prod_ff;
   logic [63:0]          acc_ff;

   // Control decoded from the state.
   logic        req_fire;
   logic        fin_commit;
   logic [15:0] mul_a;
   logic [31:0] mul_b;

   logic [31:0]         delta;
   logic [PoleBits:0]   div_trial;
   logic                div_take;
   logic [CountBits-1:0] moved_lo;
   logic [47:0]         speed_q;
   logic [31:0]         speed_sat;

   // A pole pair count of zero is handled as one.
   assign pp_eff = (pole_pairs_ff == '0) ? {{(PoleBits-1){1'b0}}, 1'b1} : pole_pairs_ff;

   assign req_fire  = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         pole_pairs_ff <= PolePairsReset;
         speed_gain_ff <= SpeedGainReset;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_POLE_PAIRS: pole_pairs_ff <= csr_data[PoleBits-1:0];
            CSR_SPEED_GAIN: speed_gain_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == OP_STARTUP) begin
                  state_in = ST_DIV;
               end else if (req_tuser == OP_INDEX && !is_aligned_ff) begin
                  state_in = ST_DIV;
               end else if (req_tuser == OP_UPDATE) begin
                  state_in = is_aligned_ff ? ST_ELEC : ST_DIV;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_DIV: begin
            if (step_ff == 4'd15) begin
               if (op_ff == OP_INDEX) begin
                  state_in = ST_POS;
               end else if (op_ff == OP_UPDATE) begin
                  state_in = ST_SPD_LO;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_POS:     state_in = ST_ELEC;
         ST_ELEC:    state_in = ST_TAKE;
         ST_TAKE:    state_in = (op_ff == OP_INDEX) ? ST_FIN : ST_SPD_LO;
         ST_SPD_LO:  state_in = ST_SPD_HI;
         ST_SPD_HI:  state_in = ST_SPD_ACC;
         ST_SPD_ACC: state_in = ST_FIN;
         ST_FIN: begin
            if (fin_commit) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // Control outputs and the operand selection of the shared multiplier.
   always_comb begin
      req_tready = 1'b0;
      fin_commit = 1'b0;
      mul_a      = {{(16-PoleBits){1'b0}}, pp_eff};
      mul_b      = {{(32-PosBits){1'b0}}, pos_ff};
      case (state_ff)
         ST_IDLE:   req_tready = 1'b1;
         ST_SPD_LO: begin
            mul_a = mag_ff[15:0];
            mul_b = speed_gain_ff;
         end
         ST_SPD_HI: begin
            mul_a = mag_ff[31:16];
            mul_b = speed_gain_ff;
         end
         ST_FIN:    fin_commit = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Restoring divider: one quotient bit per cycle, the remainder stays below the divisor.
   assign div_trial = {div_r_ff, div_q_ff[AngleBits-1]};
   assign div_take  = div_trial >= {1'b0, pp_eff};

   assign delta    = req_tdata[31:0] - previous_count_ff;
   assign moved_lo = cnt_ff[CountBits-1:0] - startup_count_ff;

   // Round to nearest was folded into the accumulator; saturate to the signed range.
   assign speed_q = acc_ff[63:16];
   always_comb begin
      if (neg_ff) begin
         speed_sat = (|speed_q[47:31]) ? 32'h8000_0000 : (32'd0 - speed_q[31:0]);
      end else begin
         speed_sat = (|speed_q[47:31]) ? 32'h7FFF_FFFF : speed_q[31:0];
      end
   end

   // Work datapath.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            op_ff           <= req_tuser;
            work_aligned_ff <= is_aligned_ff;
            cnt_ff          <= req_tdata[31:0];
            conv_ff         <= req_tdata[47:32];
            neg_ff          <= delta[31];
            mag_ff          <= delta[31] ? (32'd0 - delta) : delta;
            div_q_ff        <= (req_tuser == OP_INDEX) ? startup_elec_ff : req_tdata[47:32];
            div_r_ff        <= '0;
            step_ff         <= '0;
            // An aligned update reads the position straight from the low counter bits.
            pos_ff          <= {req_tdata[CountBits-1:0], {AngleBits{1'b0}}};
         end
         ST_DIV: begin
            div_q_ff <= {div_q_ff[AngleBits-2:0], div_take};
            div_r_ff <= div_take ? PoleBits'(div_trial - {1'b0, pp_eff})
                                 : div_trial[PoleBits-1:0];
            step_ff  <= step_ff + 4'd1;
         end
         ST_POS: begin
            // Start-up mechanical angle plus the counts moved, modulo one turn.
            pos_ff <= PosBits'({div_q_ff, {CountBits{1'b0}}})
                    + {moved_lo, {AngleBits{1'b0}}};
         end
         ST_TAKE: work_elec_ff <= prod_ff[PosBits-1:CountBits];
         ST_SPD_HI: acc_ff <= {16'd0, prod_ff} + 64'd32768;
         ST_SPD_ACC: acc_ff <= acc_ff + {prod_ff, 16'd0};
         default: ;
      endcase
      prod_ff <= mul_a * mul_b;
   end

   // Commit of the results into the held state and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         is_aligned_ff     <= 1'b0;
         startup_elec_ff   <= '0;
         startup_count_ff  <= '0;
         previous_count_ff <= '0;
         elec_held_ff      <= '0;
         mech_held_ff      <= '0;
         speed_held_ff     <= '0;
         load_ff           <= 1'b0;
         load_value_ff     <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         // A new result refills the register in the cycle the old one leaves.
         if (fin_commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (fin_commit) begin
            if (op_ff == OP_STARTUP) begin
               startup_elec_ff   <= conv_ff;
               elec_held_ff      <= conv_ff;
               mech_held_ff      <= div_q_ff;
               startup_count_ff  <= div_q_ff[AngleBits-1:AngleBits-CountBits];
               previous_count_ff <= 32'(div_q_ff[AngleBits-1:AngleBits-CountBits]);
               speed_held_ff     <= '0;
               is_aligned_ff     <= 1'b0;
               load_ff           <= 1'b1;
               load_value_ff     <= div_q_ff[AngleBits-1:AngleBits-CountBits];
            end else if (op_ff == OP_INDEX && !work_aligned_ff) begin
               is_aligned_ff     <= 1'b1;
               elec_held_ff      <= work_elec_ff;
               mech_held_ff      <= pos_ff[PosBits-1:CountBits];
               previous_count_ff <= 32'(pos_ff[PosBits-1:AngleBits]);
               load_ff           <= 1'b1;
               load_value_ff     <= pos_ff[PosBits-1:AngleBits];
            end else begin
               load_ff       <= 1'b0;
               load_value_ff <= '0;
               if (op_ff == OP_UPDATE) begin
                  if (work_aligned_ff) begin
                     elec_held_ff <= work_elec_ff;
                     mech_held_ff <= pos_ff[PosBits-1:CountBits];
                  end else begin
                     elec_held_ff <= conv_ff;
                     mech_held_ff <= div_q_ff;
                  end
                  speed_held_ff     <= speed_sat;
                  previous_count_ff <= cnt_ff;
               end
            end
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, load_value_ff, load_ff, is_aligned_ff, speed_held_ff,
                        mech_held_ff, elec_held_ff};

endmodule
